/* src/cae_pkg.sv */
// ----------------------------------------------------------------------------
// cae_pkg
// shared types and codes of the conditional alu execute stage
// ----------------------------------------------------------------------------
package cae_pkg;

    localparam int NREG = 16;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_reg_idx;

    localparam t_reg_idx PC_IDX = 4'd15;

    // instruction kinds
    localparam logic [1:0] KIND_DP     = 2'd0;
    localparam logic [1:0] KIND_MUL    = 2'd1;
    localparam logic [1:0] KIND_BRANCH = 2'd2;

    // condition codes
    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    // alu opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    // operand modes
    localparam logic [1:0] MODE_SHIFT_IMM = 2'd0;
    localparam logic [1:0] MODE_SHIFT_REG = 2'd1;

    // shift types
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // flag bit positions
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_C = 1;
    localparam int FLAG_V = 0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  cond;
        logic [3:0]  opcode;
        logic [1:0]  operand_mode;
        logic        set_flags;
        t_reg_idx    rd;
        t_reg_idx    rn;
        t_reg_idx    rm;
        t_reg_idx    rs;
        logic [1:0]  shift_type;
        logic [4:0]  shift_amount;
        logic [23:0] literal;
    } t_instr;

    typedef struct packed {
        logic     executed;
        logic     wrote_reg;
        t_reg_idx dest_reg;
        t_word    dest_value;
        logic [3:0] flag_bits;
        t_word    program_counter;
    } t_result;

    // operands handed to the execute unit
    typedef struct packed {
        t_word      rn_val;
        t_word      rm_val;
        t_word      rs_val;
        t_word      pc_val;
        logic [3:0] flags;
    } t_opnd;

endpackage

/* src/cae_in_if.sv */
// ----------------------------------------------------------------------------
// cae_in_if
// instruction channel: valid, ready and one decoded instruction
// ----------------------------------------------------------------------------
interface cae_in_if;
    import cae_pkg::*;

    logic   valid;
    logic   ready;
    t_instr data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/cae_out_if.sv */
// ----------------------------------------------------------------------------
// cae_out_if
// result channel: valid, ready and one execute result
// ----------------------------------------------------------------------------
interface cae_out_if;
    import cae_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/cae_alu.sv */
// ----------------------------------------------------------------------------
// cae_alu
// condition test, barrel shifter, alu, multiplier and branch adder
// ----------------------------------------------------------------------------
module cae_alu (
    input  cae_pkg::t_instr  i_instr,
    input  cae_pkg::t_opnd   i_opnd,
    output cae_pkg::t_result o_result
);
    import cae_pkg::*;

    function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
        logic n, z, v;
        n = f[FLAG_N];
        z = f[FLAG_Z];
        v = f[FLAG_V];
        priority case (c)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // returns {carry, value}
    function automatic logic [32:0] barrel(input t_word v, input logic [1:0] ty,
                                           input logic [7:0] amt, input logic cin);
        logic [32:0] t;
        logic [63:0] dbl;
        t = {cin, v};
        if (amt != 8'd0) begin
            unique case (ty)
                SH_LSL: begin
                    if (amt < 8'd32) t = {1'b0, v} << amt[4:0];
                    else if (amt == 8'd32) t = {v[0], 32'd0};
                    else t = 33'd0;
                end
                SH_LSR: begin
                    if (amt < 8'd32) begin
                        t = {v, 1'b0} >> amt[4:0];
                        t = {t[0], t[32:1]};
                    end else if (amt == 8'd32) begin
                        t = {v[31], 32'd0};
                    end else begin
                        t = 33'd0;
                    end
                end
                SH_ASR: begin
                    if (amt < 8'd32) begin
                        t = 33'($signed({v, 1'b0}) >>> amt[4:0]);
                        t = {t[0], t[32:1]};
                    end else begin
                        t = {v[31], {32{v[31]}}};
                    end
                end
                SH_ROR: begin
                    dbl = {v, v} >> amt[4:0];
                    t = {dbl[31], dbl[31:0]};
                end
                default: t = {cin, v};
            endcase
        end
        return t;
    endfunction

    logic        pass;
    logic        cin;
    logic [7:0]  sh_amt;
    logic [1:0]  sh_type;
    t_word       sh_val;
    logic [32:0] sh_out;
    t_word       a;
    t_word       op2;
    logic        sh_c;
    t_word       add_x, add_y;
    logic        add_cin;
    logic [32:0] sum;
    t_word       mul_lo;
    t_word       mac;
    t_word       br_off;
    t_word       res;
    logic        c_out;
    logic        op_ok;
    logic        op_wr;
    logic        exec;
    logic        wr;
    logic [3:0]  flags_nxt;

    assign pass = cond_pass(i_instr.cond, i_opnd.flags);
    assign cin  = i_opnd.flags[FLAG_C];
    assign a    = i_opnd.rn_val;

    // operand 2 selection
    always_comb begin
        if (i_instr.operand_mode[1]) begin
            sh_val  = {24'd0, i_instr.literal[7:0]};
            sh_type = SH_ROR;
            sh_amt  = {3'd0, i_instr.shift_amount[3:0], 1'b0};
        end else if (i_instr.operand_mode == MODE_SHIFT_REG) begin
            sh_val  = i_opnd.rm_val;
            sh_type = i_instr.shift_type;
            sh_amt  = i_opnd.rs_val[7:0];
        end else begin
            sh_val  = i_opnd.rm_val;
            sh_type = i_instr.shift_type;
            sh_amt  = {3'd0, i_instr.shift_amount};
        end
    end

    assign sh_out = barrel(sh_val, sh_type, sh_amt, cin);
    assign op2    = sh_out[31:0];
    assign sh_c   = sh_out[32];

    // one shared adder: sub and cmp as a + ~b + 1, rsb as b + ~a + 1
    always_comb begin
        add_x   = a;
        add_y   = op2;
        add_cin = 1'b0;
        if (i_instr.opcode == OP_SUB || i_instr.opcode == OP_CMP) begin
            add_y   = ~op2;
            add_cin = 1'b1;
        end else if (i_instr.opcode == OP_RSB) begin
            add_x   = op2;
            add_y   = ~a;
            add_cin = 1'b1;
        end
    end

    assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};

    always_comb begin
        res   = 32'd0;
        c_out = sh_c;
        op_ok = 1'b1;
        op_wr = 1'b1;
        unique case (i_instr.opcode)
            OP_AND: res = a & op2;
            OP_EOR: res = a ^ op2;
            OP_SUB, OP_RSB, OP_ADD: begin
                res   = sum[31:0];
                c_out = sum[32];
            end
            OP_TST: begin
                res   = a & op2;
                op_wr = 1'b0;
            end
            OP_TEQ: begin
                res   = a ^ op2;
                op_wr = 1'b0;
            end
            OP_CMP: begin
                res   = sum[31:0];
                c_out = sum[32];
                op_wr = 1'b0;
            end
            OP_ORR: res = a | op2;
            OP_MOV: res = op2;
            default: begin
                op_ok = 1'b0;
                op_wr = 1'b0;
            end
        endcase
    end

    assign mul_lo = 32'(i_opnd.rm_val * i_opnd.rs_val);
    assign mac    = i_instr.opcode[0] ? (mul_lo + i_opnd.rn_val) : mul_lo;
    assign br_off = {{6{i_instr.literal[23]}}, i_instr.literal, 2'b00};

    always_comb begin
        exec      = 1'b0;
        wr        = 1'b0;
        flags_nxt = i_opnd.flags;
        o_result  = '0;
        if (pass) begin
            unique case (i_instr.kind)
                KIND_DP: begin
                    exec = op_ok;
                    wr   = op_wr;
                    o_result.dest_reg   = i_instr.rd;
                    o_result.dest_value = res;
                    if (op_ok && i_instr.set_flags) begin
                        flags_nxt[FLAG_N] = res[31];
                        flags_nxt[FLAG_Z] = (res == 32'd0);
                        flags_nxt[FLAG_C] = c_out;
                    end
                end
                KIND_MUL: begin
                    exec = 1'b1;
                    wr   = 1'b1;
                    o_result.dest_reg   = i_instr.rd;
                    o_result.dest_value = mac;
                    if (i_instr.set_flags) begin
                        flags_nxt[FLAG_N] = mac[31];
                        flags_nxt[FLAG_Z] = (mac == 32'd0);
                    end
                end
                KIND_BRANCH: begin
                    exec = 1'b1;
                    wr   = 1'b1;
                    o_result.dest_reg   = PC_IDX;
                    o_result.dest_value = i_opnd.pc_val + br_off + 32'd4;
                end
                default: begin
                    exec = 1'b0;
                    wr   = 1'b0;
                end
            endcase
        end
        if (!wr) begin
            o_result.dest_reg   = '0;
            o_result.dest_value = '0;
        end
        o_result.executed        = exec;
        o_result.wrote_reg       = wr;
        o_result.flag_bits       = flags_nxt;
        o_result.program_counter = (wr && o_result.dest_reg == PC_IDX) ?
                                   o_result.dest_value : i_opnd.pc_val;
    end

endmodule

/* src/conditional_alu_execute_stage_top.sv */
// ----------------------------------------------------------------------------
// conditional_alu_execute_stage_top
// execute stage: register file in synchronous memories, flags, alu and output
//
//   channel    | direction | payload  | transfer
//   -----------+-----------+----------+---------------------------
//   i_instr    | in        | t_instr  | valid & ready at rising edge
//   o_result   | out       | t_result | valid & ready at rising edge
//
// one instruction per cycle while the output does not stall; the transaction
// edge reads the memories, the output register is loaded as the stage advances
// the register file sits in two copies of a 16 x 32 memory with registered
// read (rn, rm on one copy, rs on the other); the latest write is forwarded
// reset clears flags, pc copy and one valid bit per register, no clearing pass
// a stalled output holds the execute stage, and one more instruction may enter
// ----------------------------------------------------------------------------
module conditional_alu_execute_stage_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cae_in_if.sink    i_instr,
    cae_out_if.source o_result
);
    import cae_pkg::*;

    t_word      m_rf_a [NREG];
    t_word      m_rf_b [NREG];

    t_word      r_rn_q, r_rm_q, r_rs_q;
    logic       r_rn_ok, r_rm_ok, r_rs_ok;
    logic [NREG-1:0] r_valid;

    logic       r_s1_vld;
    t_instr     r_s1;

    logic       r_wb_vld;
    t_reg_idx   r_wb_addr;
    t_word      r_wb_data;

    t_word      r_pc;
    logic [3:0] r_flags;

    logic       r_out_vld;
    t_result    r_out;

    logic       in_acc;
    logic       s1_adv;
    logic       wr_en;
    t_opnd      opnd;
    t_result    n_result;

    assign s1_adv        = r_s1_vld && (!r_out_vld || o_result.ready);
    assign i_instr.ready = !r_s1_vld || s1_adv;
    assign in_acc        = i_instr.valid && i_instr.ready;
    assign wr_en         = s1_adv && n_result.wrote_reg;

    // register file copies, read before write
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_rf_a[n_result.dest_reg] <= n_result.dest_value;
            m_rf_b[n_result.dest_reg] <= n_result.dest_value;
        end
        if (in_acc) begin
            r_rn_q <= m_rf_a[i_instr.data.rn];
            r_rm_q <= m_rf_a[i_instr.data.rm];
            r_rs_q <= m_rf_b[i_instr.data.rs];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1    <= i_instr.data;
            r_rn_ok <= r_valid[i_instr.data.rn];
            r_rm_ok <= r_valid[i_instr.data.rm];
            r_rs_ok <= r_valid[i_instr.data.rs];
        end
        if (wr_en) begin
            r_wb_addr <= n_result.dest_reg;
            r_wb_data <= n_result.dest_value;
        end
        if (s1_adv) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_valid   <= '0;
            r_pc      <= '0;
            r_flags   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_flags   <= n_result.flag_bits;
                r_pc      <= n_result.program_counter;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_wb_vld                   <= 1'b1;
                r_valid[n_result.dest_reg] <= 1'b1;
            end
        end
    end

    // forward the latest write over what the memory returned
    always_comb begin
        opnd.rn_val = r_rn_ok ? r_rn_q : 32'd0;
        opnd.rm_val = r_rm_ok ? r_rm_q : 32'd0;
        opnd.rs_val = r_rs_ok ? r_rs_q : 32'd0;
        if (r_wb_vld && r_wb_addr == r_s1.rn) opnd.rn_val = r_wb_data;
        if (r_wb_vld && r_wb_addr == r_s1.rm) opnd.rm_val = r_wb_data;
        if (r_wb_vld && r_wb_addr == r_s1.rs) opnd.rs_val = r_wb_data;
        opnd.pc_val = r_pc;
        opnd.flags  = r_flags;
    end

    cae_alu u_cae_alu (
        .i_instr  (r_s1),
        .i_opnd   (opnd),
        .o_result (n_result)
    );

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

/* src/cae_checker.sv */
// ----------------------------------------------------------------------------
// cae_checker
// port-level checks of the execute stage, bound to the top level
// ----------------------------------------------------------------------------
module cae_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input cae_pkg::t_result i_out_data
);
    import cae_pkg::*;

    logic  r_seen;
    t_word r_last_pc;
    logic  out_acc;
    logic  pc_write;

    assign out_acc  = i_out_valid && i_out_ready;
    assign pc_write = i_out_data.wrote_reg && (i_out_data.dest_reg == PC_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_acc) begin
            r_seen <= 1'b1;
        end
        if (out_acc) begin
            r_last_pc <= i_out_data.program_counter;
        end
    end

    // pending result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // pc moves only through a write of register 15
    a_pc_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && !pc_write |-> i_out_data.program_counter == r_last_pc)
        else $error("program counter changed without a write");

    // no instruction ever sets overflow
    a_v_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_out_data.flag_bits[FLAG_V])
        else $error("overflow flag set");

    // a skipped instruction reports no write
    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.executed |-> !i_out_data.wrote_reg &&
        i_out_data.dest_reg == '0 && i_out_data.dest_value == '0)
        else $error("skipped instruction reported a write");

    // with the output register empty the stage always takes a transaction
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused with the output empty");

endmodule

bind conditional_alu_execute_stage_top cae_checker u_cae_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_instr.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the conditional alu execute stage: directed
// instructions for the shifter corners, carries, conditions, multiply, branch
// and ignored encodings, then random instruction streams, with random idle
// cycles on the instruction side and random stalls on the result side; every
// result transaction is compared with an in-order model of registers and flags
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cae_pkg::*;

    // encodings with no name in the package
    localparam logic [1:0] KIND_NONE        = 2'd3;
    localparam logic [1:0] MODE_ROT_IMM     = 2'd2;
    localparam logic [1:0] MODE_ROT_IMM_ALT = 2'd3;
    localparam logic [3:0] OP_UNUSED        = 4'd5;
    localparam logic [3:0] COND_NEVER       = 4'd15;

    localparam logic [3:0] ALU_OPS [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                                            OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};
    localparam logic [3:0] COND_SET [7] = '{COND_EQ, COND_NE, COND_GE, COND_LT,
                                            COND_GT, COND_LE, COND_AL};

    localparam int RANDOM_ITEMS = 850;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cae_in_if  instr_if();
    cae_out_if result_if();

    conditional_alu_execute_stage_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_if),
        .o_result (result_if)
    );

    always #5 i_clk = ~i_clk;

    // architectural state as the stage should see it
    t_word      arch_regs [NREG];
    logic [3:0] arch_flags;

    t_result pending_results [$];
    int      error_count = 0;
    bit      send_quiet  = 1'b0;

    int stall_left = 0;
    int phase_left = 0;
    bit drain_quiet = 1'b0;

    // mostly short, now and then long
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic cond_holds(input logic [3:0] cc);
        logic n, z, v;
        n = arch_flags[FLAG_N];
        z = arch_flags[FLAG_Z];
        v = arch_flags[FLAG_V];
        case (cc)
            COND_EQ: return z;
            COND_NE: return !z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return z || (n != v);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_word shift_operand(input t_word v, input logic [1:0] stype,
                                            input logic [7:0] amt, input logic cin,
                                            output logic cout);
        t_word      r;
        logic [4:0] a;
        r    = v;
        cout = cin;
        a    = amt[4:0];
        if (amt != 8'd0) begin
            case (stype)
                SH_LSL: begin
                    if (amt < 32) begin
                        cout = v[32 - amt];
                        r    = v << amt;
                    end else begin
                        cout = (amt == 32) ? v[0] : 1'b0;
                        r    = '0;
                    end
                end
                SH_LSR: begin
                    if (amt < 32) begin
                        cout = v[amt - 1];
                        r    = v >> amt;
                    end else begin
                        cout = (amt == 32) ? v[31] : 1'b0;
                        r    = '0;
                    end
                end
                SH_ASR: begin
                    if (amt >= 32) begin
                        cout = v[31];
                        r    = {32{v[31]}};
                    end else begin
                        cout = v[amt - 1];
                        r    = $signed(v) >>> amt;
                    end
                end
                default: begin
                    // multiples of 32 leave the value, carry from bit 31
                    if (a != 5'd0)
                        r = (v >> a) | (v << (32 - a));
                    cout = r[31];
                end
            endcase
        end
        return r;
    endfunction

    // works out the result of one instruction and updates the state
    function automatic t_result exec_instr(input t_instr ins);
        t_result res;
        t_word   a, op2, val, off;
        logic    c, cin, wr, ok;
        res = '0;
        cin = arch_flags[FLAG_C];
        if (cond_holds(ins.cond)) begin
            case (ins.kind)
                KIND_DP: begin
                    a = arch_regs[ins.rn];
                    if (ins.operand_mode[1])
                        op2 = shift_operand({24'd0, ins.literal[7:0]}, SH_ROR,
                                            {3'b000, ins.shift_amount[3:0], 1'b0}, cin, c);
                    else if (ins.operand_mode == MODE_SHIFT_REG)
                        op2 = shift_operand(arch_regs[ins.rm], ins.shift_type,
                                            arch_regs[ins.rs][7:0], cin, c);
                    else
                        op2 = shift_operand(arch_regs[ins.rm], ins.shift_type,
                                            {3'b000, ins.shift_amount}, cin, c);
                    wr = 1'b1;
                    ok = 1'b1;
                    case (ins.opcode)
                        OP_AND: val = a & op2;
                        OP_EOR: val = a ^ op2;
                        OP_SUB: begin val = a - op2; c = (a >= op2); end
                        OP_RSB: begin val = op2 - a; c = (op2 >= a); end
                        OP_ADD: begin val = a + op2; c = (val < a); end
                        OP_TST: begin val = a & op2; wr = 1'b0; end
                        OP_TEQ: begin val = a ^ op2; wr = 1'b0; end
                        OP_CMP: begin val = a - op2; c = (a >= op2); wr = 1'b0; end
                        OP_ORR: val = a | op2;
                        OP_MOV: val = op2;
                        default: begin val = '0; wr = 1'b0; ok = 1'b0; end
                    endcase
                    if (ok) begin
                        res.executed = 1'b1;
                        if (wr) begin
                            arch_regs[ins.rd] = val;
                            res.wrote_reg     = 1'b1;
                            res.dest_reg      = ins.rd;
                            res.dest_value    = val;
                        end
                        if (ins.set_flags) begin
                            arch_flags[FLAG_N] = val[31];
                            arch_flags[FLAG_Z] = (val == '0);
                            arch_flags[FLAG_C] = c;
                        end
                    end
                end
                KIND_MUL: begin
                    val = arch_regs[ins.rm] * arch_regs[ins.rs];
                    if (ins.opcode[0])
                        val = val + arch_regs[ins.rn];
                    arch_regs[ins.rd] = val;
                    res.executed   = 1'b1;
                    res.wrote_reg  = 1'b1;
                    res.dest_reg   = ins.rd;
                    res.dest_value = val;
                    if (ins.set_flags) begin
                        arch_flags[FLAG_N] = val[31];
                        arch_flags[FLAG_Z] = (val == '0);
                    end
                end
                KIND_BRANCH: begin
                    off = {{6{ins.literal[23]}}, ins.literal, 2'b00};
                    arch_regs[PC_IDX] = arch_regs[PC_IDX] + off + 32'd4;
                    res.executed   = 1'b1;
                    res.wrote_reg  = 1'b1;
                    res.dest_reg   = PC_IDX;
                    res.dest_value = arch_regs[PC_IDX];
                end
                default: ;
            endcase
        end
        res.flag_bits       = arch_flags;
        res.program_counter = arch_regs[PC_IDX];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input t_word want, input t_word got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
        end else begin
            want = pending_results.pop_front();
            check_field("executed", 32'(want.executed), 32'(got.executed));
            check_field("wrote_reg", 32'(want.wrote_reg), 32'(got.wrote_reg));
            check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
            check_field("dest_value", want.dest_value, got.dest_value);
            check_field("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
            check_field("program_counter", want.program_counter, got.program_counter);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            check_result(result_if.data);
    end

    // result side back-pressure, with calm stretches now and then
    always @(negedge i_clk) begin
        if (phase_left == 0) begin
            drain_quiet = ($urandom_range(0, 3) == 0);
            phase_left  = $urandom_range(50, 300);
        end else begin
            phase_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            result_if.ready <= 1'b0;
        end else if (!drain_quiet && $urandom_range(0, 99) < 25) begin
            stall_left = pause_len() - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    task automatic send_instr(input t_instr ins);
        int gap;
        gap = (send_quiet || $urandom_range(0, 99) < 65) ? 0 : pause_len();
        repeat (gap) begin
            @(negedge i_clk);
            instr_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        instr_if.valid <= 1'b1;
        instr_if.data  <= ins;
        @(posedge i_clk);
        while (!instr_if.ready)
            @(posedge i_clk);
        pending_results.push_back(exec_instr(ins));
    endtask

    function automatic t_instr alu_op(input logic [3:0] op, input logic [1:0] mode,
                                      input logic s, input t_reg_idx rd, input t_reg_idx rn,
                                      input t_reg_idx rm, input t_reg_idx rs,
                                      input logic [1:0] st, input logic [4:0] samt,
                                      input logic [23:0] lit);
        t_instr ins;
        ins.kind         = KIND_DP;
        ins.cond         = COND_AL;
        ins.opcode       = op;
        ins.operand_mode = mode;
        ins.set_flags    = s;
        ins.rd           = rd;
        ins.rn           = rn;
        ins.rm           = rm;
        ins.rs           = rs;
        ins.shift_type   = st;
        ins.shift_amount = samt;
        ins.literal      = lit;
        return ins;
    endfunction

    function automatic t_instr mul_op(input logic acc, input logic s, input t_reg_idx rd,
                                      input t_reg_idx rn, input t_reg_idx rm,
                                      input t_reg_idx rs);
        t_instr ins;
        ins        = alu_op(OP_AND, MODE_SHIFT_IMM, s, rd, rn, rm, rs, SH_LSL, 5'd0, 24'd0);
        ins.kind   = KIND_MUL;
        ins.opcode = {3'b000, acc};
        return ins;
    endfunction

    function automatic t_instr branch_op(input logic [23:0] lit);
        t_instr ins;
        ins      = alu_op(OP_AND, MODE_SHIFT_IMM, 1'b0, 4'd0, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd0, lit);
        ins.kind = KIND_BRANCH;
        return ins;
    endfunction

    task automatic send_when(input logic [3:0] cc, input logic [23:0] lit);
        t_instr ins;
        ins      = alu_op(OP_MOV, MODE_ROT_IMM, 1'b0, 4'd14, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd0, lit);
        ins.cond = cc;
        send_instr(ins);
    endtask

    task automatic test_immediates();
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM, 1'b1, 4'd1, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd0, 24'h0000FF));
        // 0xff rotated by two: sets n and c
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM, 1'b1, 4'd2, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd1, 24'hABCDFF));
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM, 1'b0, 4'd3, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd0, 24'h000020));
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM, 1'b0, 4'd4, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd0, 24'h000021));
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM, 1'b1, 4'd5, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd31, 24'hFFFF80));
    endtask

    task automatic test_shifter();
        // r2 = c000003f, r3 = 32, r4 = 33
        send_instr(alu_op(OP_MOV, MODE_SHIFT_IMM, 1'b1, 4'd6, 4'd0, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_MOV, MODE_SHIFT_REG, 1'b1, 4'd7, 4'd0, 4'd2, 4'd3,
                          SH_LSR, 5'd0, 24'd0));
        send_instr(alu_op(OP_MOV, MODE_SHIFT_REG, 1'b1, 4'd8, 4'd0, 4'd2, 4'd4,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_MOV, MODE_SHIFT_REG, 1'b1, 4'd9, 4'd0, 4'd2, 4'd4,
                          SH_ASR, 5'd0, 24'd0));
        send_instr(alu_op(OP_MOV, MODE_SHIFT_REG, 1'b1, 4'd10, 4'd0, 4'd2, 4'd3,
                          SH_ROR, 5'd0, 24'd0));
        send_instr(alu_op(OP_MOV, MODE_SHIFT_IMM, 1'b1, 4'd11, 4'd0, 4'd2, 4'd0,
                          SH_ASR, 5'd31, 24'd0));
    endtask

    task automatic test_arith();
        send_instr(alu_op(OP_ADD, MODE_SHIFT_IMM, 1'b1, 4'd13, 4'd2, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_SUB, MODE_SHIFT_IMM, 1'b1, 4'd13, 4'd3, 4'd4, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_RSB, MODE_SHIFT_IMM, 1'b1, 4'd13, 4'd3, 4'd4, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_TST, MODE_ROT_IMM, 1'b1, 4'd12, 4'd2, 4'd0, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_instr(alu_op(OP_TEQ, MODE_SHIFT_IMM, 1'b1, 4'd12, 4'd2, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
    endtask

    task automatic test_conditions();
        // 32 - 33: negative, borrow
        send_instr(alu_op(OP_CMP, MODE_SHIFT_IMM, 1'b1, 4'd0, 4'd3, 4'd4, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_when(COND_GE, 24'h000011);
        send_when(COND_LT, 24'h000012);
        send_when(COND_GT, 24'h000013);
        send_instr(alu_op(OP_CMP, MODE_SHIFT_IMM, 1'b1, 4'd0, 4'd3, 4'd3, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        send_when(COND_EQ, 24'h000014);
        send_when(COND_NE, 24'h000015);
        send_when(COND_LE, 24'h000016);
        send_when(COND_NEVER, 24'h000017);
    endtask

    task automatic test_multiply();
        send_instr(mul_op(1'b0, 1'b1, 4'd12, 4'd0, 4'd3, 4'd4));
        send_instr(mul_op(1'b1, 1'b1, 4'd12, 4'd1, 4'd2, 4'd2));
    endtask

    task automatic test_branch();
        send_instr(branch_op(24'h000010));
        send_instr(branch_op(24'hFFFFFF));
        send_instr(branch_op(24'h800000));
        // pc written by an alu op
        send_instr(alu_op(OP_MOV, MODE_SHIFT_IMM, 1'b0, PC_IDX, 4'd0, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
    endtask

    task automatic test_ignored();
        t_instr ins;
        send_instr(alu_op(OP_UNUSED, MODE_SHIFT_IMM, 1'b1, 4'd1, 4'd2, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0));
        ins      = alu_op(OP_MOV, MODE_SHIFT_IMM, 1'b1, 4'd1, 4'd0, 4'd2, 4'd0,
                          SH_LSL, 5'd0, 24'd0);
        ins.kind = KIND_NONE;
        send_instr(ins);
        // decoded as a rotated immediate
        send_instr(alu_op(OP_MOV, MODE_ROT_IMM_ALT, 1'b1, 4'd1, 4'd0, 4'd0, 4'd0,
                          SH_LSL, 5'd4, 24'h0000A5));
    endtask

    function automatic t_instr random_instr();
        t_instr      ins;
        logic [63:0] raw;
        int          r;
        raw = {$urandom, $urandom};
        ins = raw[$bits(t_instr)-1:0];
        r   = $urandom_range(0, 99);
        if (r < 60)
            ins.kind = KIND_DP;
        else if (r < 78)
            ins.kind = KIND_MUL;
        else if (r < 93)
            ins.kind = KIND_BRANCH;
        r = $urandom_range(0, 99);
        if (r < 60)
            ins.cond = COND_AL;
        else if (r < 92)
            ins.cond = COND_SET[$urandom_range(0, 6)];
        if (ins.kind == KIND_DP) begin
            if ($urandom_range(0, 99) < 90)
                ins.opcode = ALU_OPS[$urandom_range(0, 9)];
            // small constants feed register shift amounts around 32
            if ($urandom_range(0, 99) < 20) begin
                ins.opcode          = OP_MOV;
                ins.operand_mode    = MODE_ROT_IMM;
                ins.shift_amount    = 5'd0;
                ins.literal[7:0]    = 8'($urandom_range(0, 70));
            end
        end
        return ins;
    endfunction

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            send_instr(random_instr());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        instr_if.valid  = 1'b0;
        instr_if.data   = '0;
        result_if.ready = 1'b0;
        for (int i = 0; i < NREG; i++)
            arch_regs[i] = '0;
        arch_flags = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_immediates();
        test_shifter();
        test_arith();
        test_conditions();
        test_multiply();
        test_branch();
        test_ignored();
        test_random();

        @(negedge i_clk);
        instr_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
